// File: rtl/pgv_pkg.sv
`default_nettype none

package pgv_pkg;

    // item action codes
    localparam logic [1:0] ACT_PRIOR   = 2'd0;
    localparam logic [1:0] ACT_CHANNEL = 2'd1;
    localparam logic [1:0] ACT_GAIN    = 2'd2;
    localparam logic [1:0] ACT_COMPUTE = 2'd3;

    // register indexes on the apb port
    localparam logic [1:0] REG_NUM_INPUTS  = 2'd0;
    localparam logic [1:0] REG_NUM_OUTPUTS = 2'd1;
    localparam logic [1:0] REG_NUM_GUESSES = 2'd2;

    localparam int CFG_W     = 7;
    localparam int DIM_W     = 11;   // holds any dimension up to 1024
    localparam int WORD_W    = 16;
    localparam int PC_W      = 32;   // prior times channel, 30 fraction bits
    localparam int PROD_W    = 49;   // signed term, 42 fraction bits
    localparam int VUL_W     = 40;
    localparam int FRAC_DROP = 15;   // 42 -> 27 fraction bits
    localparam int CAP_BIT   = 56;   // running total is clipped at 2^56

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // loop position markers that travel with each term down the pipeline
    typedef struct packed {
        logic first_x;
        logic last_x;
        logic first_w;
        logic last_w;
        logic last_y;
    } t_tag;

    // last loop index for a dimension clipped to its maximum
    function automatic logic [DIM_W-1:0] f_last_index(input logic [CFG_W-1:0] n,
                                                      input logic [DIM_W-1:0] max_n);
        logic [DIM_W-1:0] v;
        v = {{(DIM_W-CFG_W){1'b0}}, n};
        if (v > max_n) begin
            v = max_n;
        end
        return v - {{(DIM_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

// File: rtl/posterior_g_vulnerability_unit.sv
`default_nettype none

// Posterior g-vulnerability engine. Prior, channel and gain words are loaded one
// transaction each (action 0, 1, 2); a compute transaction (action 3) then
// returns one result transaction holding the sum over output columns of the best
// guess sum, floored at zero, with 27 fraction bits and a saturation flag. A
// compute issues num_outputs * num_guesses * num_inputs terms (each clipped to
// its maximum) before the pipeline drains and the result is handed to the output
// register: one multiply-accumulate pipeline is shared by every term and
// consumes one term per cycle. If any dimension is zero the result is zero. A
// new result waits while a result still stalled at the output is not yet taken.
// The input side stalls from the start of a compute until its result has
// moved into the output register; loads may be taken while a finished result is
// still waiting at the output. The stores are not cleared by reset, so every entry
// a compute touches must be loaded first. Loads with an index beyond the store are
// dropped. Registers (num_inputs, num_outputs, num_guesses) sit at byte addresses
// 0, 4 and 8 and must be written only while the block is idle.
module posterior_g_vulnerability_unit
    import pgv_pkg::*;
#(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_OUTPUTS = 64,
    parameter int MAX_GUESSES = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input transactions
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_action,
    input  wire logic [5:0]          i_row,
    input  wire logic [5:0]          i_col,
    input  wire logic [WORD_W-1:0]   i_word,
    // result transactions
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [VUL_W-1:0]         o_vulnerability,
    output logic                     o_saturated,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int XW = (MAX_INPUTS  > 1) ? $clog2(MAX_INPUTS)  : 1;
    localparam int YW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int GW = (MAX_GUESSES > 1) ? $clog2(MAX_GUESSES) : 1;
    localparam int SW = PROD_W + XW;                      // signed guess sum
    localparam int AW = ((SW > CAP_BIT + 1) ? SW : CAP_BIT + 1) + 1;  // total

    localparam logic [DIM_W-1:0] MAX_X = DIM_W'(MAX_INPUTS);
    localparam logic [DIM_W-1:0] MAX_Y = DIM_W'(MAX_OUTPUTS);
    localparam logic [DIM_W-1:0] MAX_G = DIM_W'(MAX_GUESSES);
    localparam logic [AW-1:0] ACC_CAP = {{(AW-CAP_BIT-1){1'b0}}, 1'b1, {CAP_BIT{1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_num_inputs;
    logic [CFG_W-1:0] r_num_outputs;
    logic [CFG_W-1:0] r_num_guesses;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_inputs  <= CFG_W'(1);
            r_num_outputs <= CFG_W'(1);
            r_num_guesses <= CFG_W'(1);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_NUM_INPUTS:  r_num_inputs  <= pwdata[CFG_W-1:0];
                REG_NUM_OUTPUTS: r_num_outputs <= pwdata[CFG_W-1:0];
                REG_NUM_GUESSES: r_num_guesses <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NUM_INPUTS:  prdata = {{(32-CFG_W){1'b0}}, r_num_inputs};
            REG_NUM_OUTPUTS: prdata = {{(32-CFG_W){1'b0}}, r_num_outputs};
            REG_NUM_GUESSES: prdata = {{(32-CFG_W){1'b0}}, r_num_guesses};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // input acceptance and store writes
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   start;
    logic   any_zero;

    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] col_ext;
    logic             wr_prior;
    logic             wr_channel;
    logic             wr_gain;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign start      = in_acc && (i_action == ACT_COMPUTE);
    assign any_zero   = (r_num_inputs == '0) || (r_num_outputs == '0) ||
                        (r_num_guesses == '0);

    assign row_ext    = {{(DIM_W-6){1'b0}}, i_row};
    assign col_ext    = {{(DIM_W-6){1'b0}}, i_col};
    assign wr_prior   = in_acc && (i_action == ACT_PRIOR) && (row_ext < MAX_X);
    assign wr_channel = in_acc && (i_action == ACT_CHANNEL) && (row_ext < MAX_X) &&
                        (col_ext < MAX_Y);
    assign wr_gain    = in_acc && (i_action == ACT_GAIN) && (row_ext < MAX_G) &&
                        (col_ext < MAX_X);

    // ------------------------------------------------------------------
    // loop sequencer: y outer, guess middle, x inner
    // ------------------------------------------------------------------
    logic [XW-1:0] r_x,      n_x;
    logic [YW-1:0] r_y,      n_y;
    logic [GW-1:0] r_w,      n_w;
    logic [XW-1:0] r_x_last;
    logic [YW-1:0] r_y_last;
    logic [GW-1:0] r_w_last;
    logic          x_end;
    logic          w_end;
    logic          y_end;
    logic          issue;
    logic          out_load;
    logic          r_fin;
    logic          r_out_valid;
    t_tag          issue_tag;

    assign x_end = (r_x == r_x_last);
    assign w_end = (r_w == r_w_last);
    assign y_end = (r_y == r_y_last);
    assign issue = (r_state == ST_RUN);

    assign issue_tag.first_x = (r_x == '0);
    assign issue_tag.last_x  = x_end;
    assign issue_tag.first_w = (r_w == '0);
    assign issue_tag.last_w  = w_end;
    assign issue_tag.last_y  = y_end;

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_w      = r_w;
        n_y      = r_y;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = any_zero ? ST_OUT : ST_RUN;
                    n_x     = '0;
                    n_w     = '0;
                    n_y     = '0;
                end
            end
            ST_RUN: begin
                // one term issued per cycle
                if (!x_end) begin
                    n_x = r_x + XW'(1);
                end else begin
                    n_x = '0;
                    if (!w_end) begin
                        n_w = r_w + GW'(1);
                    end else begin
                        n_w = '0;
                        if (!y_end) begin
                            n_y = r_y + YW'(1);
                        end else begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                // last column maximum has been added
                if (r_fin) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_w <= n_w;
        r_y <= n_y;
        if (start) begin
            r_x_last <= XW'(f_last_index(r_num_inputs, MAX_X));
            r_y_last <= YW'(f_last_index(r_num_outputs, MAX_Y));
            r_w_last <= GW'(f_last_index(r_num_guesses, MAX_G));
        end
    end

    // ------------------------------------------------------------------
    // stores, one write and one registered read each
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] prior_mem   [2**XW];
    logic [WORD_W-1:0] channel_mem [2**(XW+YW)];
    logic [WORD_W-1:0] gain_mem    [2**(GW+XW)];

    logic [WORD_W-1:0] r_p1;
    logic [WORD_W-1:0] r_c1;
    logic [WORD_W-1:0] r_g1;

    always_ff @(posedge i_clk) begin
        if (wr_prior) begin
            prior_mem[row_ext[XW-1:0]] <= i_word;
        end
        r_p1 <= prior_mem[r_x];
    end

    always_ff @(posedge i_clk) begin
        if (wr_channel) begin
            channel_mem[{row_ext[XW-1:0], col_ext[YW-1:0]}] <= i_word;
        end
        r_c1 <= channel_mem[{r_x, r_y}];
    end

    always_ff @(posedge i_clk) begin
        if (wr_gain) begin
            gain_mem[{row_ext[GW-1:0], col_ext[XW-1:0]}] <= i_word;
        end
        r_g1 <= gain_mem[{r_w, r_x}];
    end

    // ------------------------------------------------------------------
    // shared multiply-accumulate pipeline
    //   stage 1 store read, stage 2 prior*channel, stage 3 times gain,
    //   stage 4 guess sum, stage 5 column maximum, stage 6 running total
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_tag r_t1, r_t2, r_t3, r_t4, r_t5;

    logic        [PC_W-1:0]   r_pc2;
    logic        [WORD_W-1:0] r_g2;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod3;
    logic signed [SW-1:0]     prod_ext;
    logic signed [SW-1:0]     r_sum;
    logic        [SW-2:0]     sum_pos;
    logic        [SW-2:0]     n_best;
    logic        [SW-2:0]     r_best;
    logic        [AW-1:0]     n_acc;
    logic        [AW-1:0]     r_acc;

    assign n_prod   = $signed({1'b0, r_pc2}) * $signed(r_g2);
    assign prod_ext = {{XW{r_prod3[PROD_W-1]}}, r_prod3};

    // guess sum floored at zero, then compared with the best so far
    assign sum_pos = r_sum[SW-1] ? '0 : r_sum[SW-2:0];
    always_comb begin
        if (r_t4.first_w || (sum_pos > r_best)) begin
            n_best = sum_pos;
        end else begin
            n_best = r_best;
        end
    end

    always_comb begin
        n_acc = r_acc + {{(AW-SW+1){1'b0}}, r_best};
        if (n_acc > ACC_CAP) begin
            n_acc = ACC_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_v1  <= issue;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4 && r_t4.last_x;
            r_fin <= r_v5 && r_t5.last_w && r_t5.last_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1    <= issue_tag;
        r_t2    <= r_t1;
        r_t3    <= r_t2;
        r_t4    <= r_t3;
        r_t5    <= r_t4;
        r_pc2   <= {{(PC_W-WORD_W){1'b0}}, r_p1} * {{(PC_W-WORD_W){1'b0}}, r_c1};
        r_g2    <= r_g1;
        r_prod3 <= n_prod;
        if (r_v3) begin
            r_sum <= r_t3.first_x ? prod_ext : r_sum + prod_ext;
        end
        if (r_v4 && r_t4.last_x) begin
            r_best <= n_best;
        end
        if (start) begin
            r_acc <= '0;
        end else if (r_v5 && r_t5.last_w) begin
            r_acc <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // output register: drop 15 fraction bits and saturate at 40 bits
    // ------------------------------------------------------------------
    logic             res_sat;
    logic [VUL_W-1:0] r_out_vul;
    logic             r_out_sat;

    assign res_sat = |r_acc[AW-1:VUL_W+FRAC_DROP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_vul <= res_sat ? '1 : r_acc[VUL_W+FRAC_DROP-1:FRAC_DROP];
            r_out_sat <= res_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_vulnerability = r_out_vul;
    assign o_saturated     = r_out_sat;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // terms only enter the pipeline from the issue state
    a_issue_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(r_state) == ST_RUN)
        else $error("pipeline term without issue");

    // the final column is added only while draining
    a_fin_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> r_state == ST_DRAIN)
        else $error("total finished outside drain");

    // the pipeline is empty whenever the block accepts items
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_fin))
        else $error("pipeline busy while idle");

    // a clipped result carries the largest value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (&o_vulnerability))
        else $error("saturated result not at full scale");

endmodule

`default_nettype wire

// File: tb/tb_posterior_g_vulnerability_unit.sv
`default_nettype none

module tb_posterior_g_vulnerability_unit;
    import pgv_pkg::*;

    localparam int          DIM_MAX       = 64;
    localparam int          ITEM_TARGET   = 1450;
    localparam int          SETTLE_CYCLES = 16;
    localparam logic [63:0] ACC_CAP       = 64'd1 << CAP_BIT;
    localparam logic [VUL_W-1:0] VUL_LIMIT = '1;

    typedef struct packed {
        logic [VUL_W-1:0] vul;
        logic             sat;
    } t_result;

    localparam t_result NO_RESULT = '0;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } t_row_kind;

    // one directed step: an input transaction or a register write
    // (code is the action or the register index, word the data or register value)
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  code;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] word;
        logic        typed;
        t_result     expected;
    } t_step;

    // clock and block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_action = ACT_PRIOR;
    logic [5:0]        i_row = '0;
    logic [5:0]        i_col = '0;
    logic [WORD_W-1:0] i_word = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [VUL_W-1:0]  o_vulnerability;
    logic              o_saturated;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // shadow copy of the block state
    logic [15:0] prior_mem [DIM_MAX];
    logic [15:0] chan_mem  [DIM_MAX][DIM_MAX];
    logic [15:0] gain_mem  [DIM_MAX][DIM_MAX];
    bit          prior_done [DIM_MAX];
    bit          chan_done  [DIM_MAX][DIM_MAX];
    bit          gain_done  [DIM_MAX][DIM_MAX];
    logic [CFG_W-1:0] cfg_inputs  = 7'd1;
    logic [CFG_W-1:0] cfg_outputs = 7'd1;
    logic [CFG_W-1:0] cfg_guesses = 7'd1;

    t_result     vulnerability_queue [$];
    int unsigned mismatch_count = 0;
    int unsigned sent_items = 0;
    bit          gapless = 1'b0;
    int unsigned stall_hold = 0;

    // directed steps, typed expectations only where obvious
    t_step directed_steps [24] = '{
        // 1.0 * 1.0 * 1.0 gives exactly one
        '{ROW_ITEM, ACT_PRIOR,   6'd0,  6'd0,  16'h8000, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_CHANNEL, 6'd0,  6'd0,  16'h8000, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_GAIN,    6'd0,  6'd0,  16'h1000, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_COMPUTE, 6'd0,  6'd0,  16'h0000, 1'b1, '{40'h0008000000, 1'b0}},
        // most negative gain, floored at zero
        '{ROW_ITEM, ACT_GAIN,    6'd0,  6'd0,  16'h8000, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_COMPUTE, 6'd63, 6'd63, 16'hffff, 1'b1, NO_RESULT},
        // largest positive gain with full-scale words
        '{ROW_ITEM, ACT_GAIN,    6'd0,  6'd0,  16'h7fff, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_PRIOR,   6'd0,  6'd0,  16'hffff, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_CHANNEL, 6'd0,  6'd0,  16'hffff, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_COMPUTE, 6'd21, 6'd42, 16'h5a5a, 1'b0, NO_RESULT},
        // top corners of the stores
        '{ROW_ITEM, ACT_PRIOR,   6'd63, 6'd0,  16'hffff, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_CHANNEL, 6'd63, 6'd63, 16'h0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_GAIN,    6'd63, 6'd63, 16'hffff, 1'b0, NO_RESULT},
        // each dimension set to zero gives zero
        '{ROW_REG,  REG_NUM_OUTPUTS, 6'd0, 6'd0, 16'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_COMPUTE, 6'd0,  6'd0,  16'h0000, 1'b1, NO_RESULT},
        '{ROW_REG,  REG_NUM_OUTPUTS, 6'd0, 6'd0, 16'd1, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_NUM_GUESSES, 6'd0, 6'd0, 16'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_COMPUTE, 6'd0,  6'd0,  16'h0000, 1'b1, NO_RESULT},
        '{ROW_REG,  REG_NUM_GUESSES, 6'd0, 6'd0, 16'd1, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_NUM_INPUTS,  6'd0, 6'd0, 16'd0, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_COMPUTE, 6'd0,  6'd0,  16'h0000, 1'b1, NO_RESULT},
        '{ROW_REG,  REG_NUM_INPUTS,  6'd0, 6'd0, 16'd1, 1'b0, NO_RESULT},
        // zero prior wipes everything out
        '{ROW_ITEM, ACT_PRIOR,   6'd0,  6'd0,  16'h0000, 1'b0, NO_RESULT},
        '{ROW_ITEM, ACT_COMPUTE, 6'd0,  6'd0,  16'h0000, 1'b1, NO_RESULT}
    };

    posterior_g_vulnerability_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_word          (i_word),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_vulnerability (o_vulnerability),
        .o_saturated     (o_saturated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // registers above the store size are used clipped
    function automatic int unsigned clip_dim(input logic [CFG_W-1:0] n);
        return (n > DIM_MAX) ? DIM_MAX : int'(n);
    endfunction

    // sum over columns of the best guess sum, exact at 42 fraction bits,
    // running total capped, then cut to 27 fraction bits and saturated
    function automatic t_result compute_vulnerability();
        int unsigned ni;
        int unsigned no;
        int unsigned ng;
        longint      guess_sum;
        longint      best;
        logic [63:0] total;
        logic [63:0] scaled;
        t_result     res;
        ni = clip_dim(cfg_inputs);
        no = clip_dim(cfg_outputs);
        ng = clip_dim(cfg_guesses);
        total = '0;
        for (int y = 0; y < no; y++) begin
            best = 0;
            for (int w = 0; w < ng; w++) begin
                guess_sum = 0;
                for (int x = 0; x < ni; x++)
                    guess_sum += longint'(prior_mem[x]) * longint'(chan_mem[x][y])
                                 * longint'($signed(gain_mem[w][x]));
                if (guess_sum > best) begin
                    best = guess_sum;
                end
            end
            total += 64'(best);
            if (total > ACC_CAP) begin
                total = ACC_CAP;
            end
        end
        scaled = total >> FRAC_DROP;
        res.sat = (scaled > 64'(VUL_LIMIT));
        res.vul = res.sat ? VUL_LIMIT : scaled[VUL_W-1:0];
        return res;
    endfunction

    // update the shadow state for an accepted transaction
    function automatic void take_item(input logic [1:0] act, input logic [5:0] r,
                                      input logic [5:0] c, input logic [15:0] w,
                                      input logic typed, input t_result typed_res);
        case (act)
            ACT_PRIOR: begin
                prior_mem[r] = w;
                prior_done[r] = 1'b1;
            end
            ACT_CHANNEL: begin
                chan_mem[r][c] = w;
                chan_done[r][c] = 1'b1;
            end
            ACT_GAIN: begin
                gain_mem[r][c] = w;
                gain_done[r][c] = 1'b1;
            end
            default: begin
                vulnerability_queue.insert(vulnerability_queue.size(),
                                           typed ? typed_res : compute_vulnerability());
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gapless || r < 65) begin
            return 0;
        end
        return (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    // full-scale and sign-boundary words show up often
    function automatic logic [15:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 16'h0000;
        end else if (r < 20) begin
            return 16'hffff;
        end else if (r < 25) begin
            return 16'h8000;
        end else if (r < 30) begin
            return 16'h7fff;
        end
        return 16'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return '0;
        end else if (r < 85) begin
            return 7'($urandom_range(1, 6));
        end
        return 7'($urandom_range(7, 12));
    endfunction

    // one input transaction; returns at the edge where it was accepted
    task automatic send_item(input logic [1:0] act, input logic [5:0] r, input logic [5:0] c,
                             input logic [15:0] w, input logic typed,
                             input t_result typed_res);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_row      <= r;
        i_col      <= c;
        i_word     <= w;
        do @(posedge i_clk); while (o_in_stall);
        take_item(act, r, c, w, typed, typed_res);
        sent_items++;
    endtask

    // hold off the sender until every pending result has been seen
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (vulnerability_queue.size() != 0);
    endtask

    // register write, only with the block idle
    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUM_INPUTS:  cfg_inputs  = value;
            REG_NUM_OUTPUTS: cfg_outputs = value;
            REG_NUM_GUESSES: cfg_guesses = value;
            default: ;
        endcase
    endtask

    // load every entry a compute will read; full-scale words force saturation
    task automatic fill_region(input bit full_scale);
        int unsigned ni;
        int unsigned no;
        int unsigned ng;
        ni = clip_dim(cfg_inputs);
        no = clip_dim(cfg_outputs);
        ng = clip_dim(cfg_guesses);
        for (int x = 0; x < ni; x++) begin
            if (full_scale || !prior_done[x]) begin
                send_item(ACT_PRIOR, 6'(x), 6'($urandom), full_scale ? 16'hffff : pick_word(),
                          1'b0, NO_RESULT);
            end
            for (int y = 0; y < no; y++) begin
                if (full_scale || !chan_done[x][y]) begin
                    send_item(ACT_CHANNEL, 6'(x), 6'(y),
                              full_scale ? 16'hffff : pick_word(), 1'b0, NO_RESULT);
                end
            end
            for (int g = 0; g < ng; g++) begin
                if (full_scale || !gain_done[g][x]) begin
                    send_item(ACT_GAIN, 6'(g), 6'(x),
                              full_scale ? 16'h7fff : pick_word(), 1'b0, NO_RESULT);
                end
            end
        end
    endtask

    // mostly loads inside the active region, some stray loads, some computes
    task automatic random_item();
        int unsigned pick;
        int unsigned ni;
        int unsigned no;
        int unsigned ng;
        logic [1:0]  act;
        logic [5:0]  r;
        logic [5:0]  c;
        ni = clip_dim(cfg_inputs);
        no = clip_dim(cfg_outputs);
        ng = clip_dim(cfg_guesses);
        pick = $urandom_range(0, 99);
        act = 2'($urandom_range(0, 2));
        r = 6'($urandom);
        c = 6'($urandom);
        if (pick < 3) begin
            drain();
        end else if (pick < 18) begin
            send_item(ACT_COMPUTE, r, c, 16'($urandom), 1'b0, NO_RESULT);
        end else begin
            if (pick >= 28) begin
                case (act)
                    ACT_PRIOR: begin
                        if (ni != 0) begin
                            r = 6'($urandom_range(0, ni - 1));
                        end
                    end
                    ACT_CHANNEL: begin
                        if (ni != 0 && no != 0) begin
                            r = 6'($urandom_range(0, ni - 1));
                            c = 6'($urandom_range(0, no - 1));
                        end
                    end
                    default: begin
                        if (ng != 0 && ni != 0) begin
                            r = 6'($urandom_range(0, ng - 1));
                            c = 6'($urandom_range(0, ni - 1));
                        end
                    end
                endcase
            end
            send_item(act, r, c, pick_word(), 1'b0, NO_RESULT);
        end
    endtask

    // new setting, fill, an immediate compute, then a random burst
    task automatic run_phase(input logic [CFG_W-1:0] n_in, input logic [CFG_W-1:0] n_out,
                             input logic [CFG_W-1:0] n_guess, input bit full_scale,
                             input int unsigned len);
        cfg_write(REG_NUM_INPUTS, n_in);
        cfg_write(REG_NUM_OUTPUTS, n_out);
        cfg_write(REG_NUM_GUESSES, n_guess);
        gapless = ($urandom_range(0, 3) == 0);
        fill_region(full_scale);
        send_item(ACT_COMPUTE, 6'($urandom), 6'($urandom), 16'($urandom), 1'b0, NO_RESULT);
        repeat (len) random_item();
    endtask

    // result side stall: short stalls, a few long ones, and free stretches
    always @(posedge i_clk) begin
        int unsigned r;
        if (stall_hold != 0) begin
            stall_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                i_out_stall <= 1'b0;
                stall_hold = $urandom_range(0, 6);
            end else if (r < 65) begin
                i_out_stall <= 1'b0;
                stall_hold = $urandom_range(20, 60);
            end else if (r < 95) begin
                i_out_stall <= 1'b1;
                stall_hold = $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold = $urandom_range(10, 30);
            end
        end
    end

    // every accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (vulnerability_queue.size() == 0) begin
                note_mismatch("result with none pending", 64'd0, 64'(o_vulnerability));
            end else begin
                want = vulnerability_queue.pop_front();
                if (o_vulnerability !== want.vul) begin
                    note_mismatch("vulnerability", 64'(want.vul), 64'(o_vulnerability));
                end
                if (o_saturated !== want.sat) begin
                    note_mismatch("saturated", 64'(want.sat), 64'(o_saturated));
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k]) begin
            if (directed_steps[k].kind == ROW_REG) begin
                cfg_write(directed_steps[k].code, directed_steps[k].word[CFG_W-1:0]);
            end else begin
                send_item(directed_steps[k].code, directed_steps[k].row, directed_steps[k].col,
                          directed_steps[k].word, directed_steps[k].typed,
                          directed_steps[k].expected);
            end
        end

        // register extremes: above the store size (clipped), exactly the size,
        // and an overflow that saturates the result
        run_phase(7'd127, 7'd1, 7'd1, 1'b0, 20);
        run_phase(7'd1, 7'd127, 7'd1, 1'b0, 20);
        run_phase(7'd1, 7'd1, 7'd127, 1'b0, 20);
        run_phase(7'd64, 7'd1, 7'd2, 1'b0, 20);
        run_phase(7'd16, 7'd32, 7'd1, 1'b1, 10);

        while (sent_items < ITEM_TARGET)
            run_phase(pick_dim(), pick_dim(), pick_dim(), 1'b0, $urandom_range(15, 50));

        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("posterior_g_vulnerability_unit: match");
        end else begin
            $display("posterior_g_vulnerability_unit: mismatch");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #40_000_000;
        $display("posterior_g_vulnerability_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
